// File: src/agac_pkg.sv
// Shared types, constants and helper functions for the affine-gap alignment cell.
// Used by the register block, the cell arithmetic and the top level; depends on nothing.
`timescale 1ns / 1ps

package agac_pkg;

   localparam int SCORE_BITS      = 16;
   localparam int CHAR_BITS       = 8;
   localparam int CHAR_FIELD_BITS = 8;
   localparam int COST_BITS       = 8;
   localparam int CSR_INDEX_BITS  = 3;

   typedef logic signed [SCORE_BITS-1:0] score_type;
   typedef logic signed [SCORE_BITS:0]   sum_type;
   typedef logic signed [COST_BITS-1:0]  cost_type;
   typedef logic [CHAR_FIELD_BITS-1:0]   char_type;

   typedef enum logic [2:0] {
      TRACE_PAD       = 3'd0,
      TRACE_DIAG      = 3'd1,
      TRACE_LEFT_OPEN = 3'd2,
      TRACE_LEFT_EXT  = 3'd3,
      TRACE_UP_OPEN   = 3'd4,
      TRACE_UP_EXT    = 3'd5
   } trace_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LOCAL_MODE       = 3'd0,
      CSR_GAP_OPEN         = 3'd1,
      CSR_GAP_EXTEND       = 3'd2,
      CSR_MATCH_BONUS      = 3'd3,
      CSR_MISMATCH_PENALTY = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic     local_mode;
      cost_type gap_open;
      cost_type gap_extend;
      cost_type match_bonus;
      cost_type mismatch_penalty;
   } cfg_type;

   typedef struct packed {
      char_type  ref_char;
      char_type  query_char;
      score_type above_score;
      score_type left_score;
      score_type diag_score;
      score_type up_vertical_gap;
      score_type left_horizontal_gap;
   } item_type;

   typedef struct packed {
      score_type cell_score;
      score_type vertical_gap;
      score_type horizontal_gap;
      trace_type trace_code;
   } result_type;

   // Score plus cost, saturated at the signed score range.
   function automatic score_type sat_add(score_type a, cost_type b);
      sum_type s;
      s = sum_type'(a) + sum_type'(b);
      if (s[SCORE_BITS] != s[SCORE_BITS-1]) begin
         return {s[SCORE_BITS], {(SCORE_BITS-1){~s[SCORE_BITS]}}};
      end
      return s[SCORE_BITS-1:0];
   endfunction

endpackage

// File: src/agac_csr.sv
// Configuration registers of the alignment cell: gap costs, match costs and mode.
// Depends on agac_pkg for the register index codes and the configuration struct.
`timescale 1ns / 1ps

module agac_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [agac_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [agac_pkg::COST_BITS-1:0]        csr_data,
   output agac_pkg::cfg_type                     cfg
);
   import agac_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_LOCAL_MODE:       cfg_in.local_mode       = csr_data[0];
            CSR_GAP_OPEN:         cfg_in.gap_open         = cost_type'(csr_data);
            CSR_GAP_EXTEND:       cfg_in.gap_extend       = cost_type'(csr_data);
            CSR_MATCH_BONUS:      cfg_in.match_bonus      = cost_type'(csr_data);
            CSR_MISMATCH_PENALTY: cfg_in.mismatch_penalty = cost_type'(csr_data);
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_mode       <= 1'b0;
         cfg_ff.gap_open         <= cost_type'(-2);
         cfg_ff.gap_extend       <= cost_type'(-1);
         cfg_ff.match_bonus      <= cost_type'(1);
         cfg_ff.mismatch_penalty <= cost_type'(-1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/agac_calc.sv
// Cell arithmetic: saturating sums, gap maxima, best score, traceback and clamp.
// Purely combinational; depends on agac_pkg for types and the saturating add.
`timescale 1ns / 1ps

module agac_calc (
   input  agac_pkg::cfg_type    cfg,
   input  agac_pkg::item_type   item,
   output agac_pkg::result_type result
);
   import agac_pkg::*;

   logic [CHAR_BITS-1:0] rc;
   logic [CHAR_BITS-1:0] qc;
   score_type a1, a2, a3, a4;
   score_type iy, ix, gap, dg, best;
   cost_type  sub_cost;
   trace_type tb;

   assign rc = item.ref_char[CHAR_BITS-1:0];
   assign qc = item.query_char[CHAR_BITS-1:0];

   assign sub_cost = (qc == rc) ? cfg.match_bonus : cfg.mismatch_penalty;

   assign a1 = sat_add(item.left_score, cfg.gap_open);
   assign a2 = sat_add(item.left_horizontal_gap, cfg.gap_extend);
   assign a3 = sat_add(item.above_score, cfg.gap_open);
   assign a4 = sat_add(item.up_vertical_gap, cfg.gap_extend);
   assign dg = sat_add(item.diag_score, sub_cost);

   assign iy   = (a1 > a2) ? a1 : a2;
   assign ix   = (a3 > a4) ? a3 : a4;
   assign gap  = (iy > ix) ? iy : ix;
   assign best = (gap > dg) ? gap : dg;

   // The diagonal wins ties; among gaps the first equal term in order wins.
   always_comb begin
      if (best == dg) begin
         tb = TRACE_DIAG;
      end else if (best == a1) begin
         tb = TRACE_LEFT_OPEN;
      end else if (best == a2) begin
         tb = TRACE_LEFT_EXT;
      end else if (best == a3) begin
         tb = TRACE_UP_OPEN;
      end else begin
         tb = TRACE_UP_EXT;
      end
   end

   always_comb begin
      if (qc == '0) begin
         result.cell_score     = '0;
         result.vertical_gap   = '0;
         result.horizontal_gap = '0;
         result.trace_code     = TRACE_PAD;
      end else begin
         result.cell_score     = (cfg.local_mode && best < 0) ? score_type'(0) : best;
         result.vertical_gap   = ix;
         result.horizontal_gap = iy;
         result.trace_code     = tb;
      end
   end

endmodule

// File: src/affine_gap_align_cell.sv
// Top level of the affine-gap alignment cell: input register, cell arithmetic, result register.
// Depends on agac_pkg, agac_csr and agac_calc.
`timescale 1ns / 1ps
//
//   Channel   Direction   Handshake            Beat contents
//   req_      in          req_valid/req_stall  two characters, three scores, two gap scores
//   rsp_      out         rsp_valid/rsp_stall  cell score, two gap scores, trace code
//   csr_      in          csr_valid/csr_ready  register index and 8-bit write data
//
// Each beat passes through the input register and then the result register, with the whole
// cell computation between them.
// A new beat can be accepted every cycle while req_stall is low; throughput is one beat per clock.
// Synchronous reset empties both stages and loads the default costs in global mode.
// A stall on the result side holds the result register, and req_stall rises only once
// both the input register and the result register are full.

module affine_gap_align_cell (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  agac_pkg::char_type                   req_ref_char,
   input  agac_pkg::char_type                   req_query_char,
   input  agac_pkg::score_type                  req_above_score,
   input  agac_pkg::score_type                  req_left_score,
   input  agac_pkg::score_type                  req_diag_score,
   input  agac_pkg::score_type                  req_up_vertical_gap,
   input  agac_pkg::score_type                  req_left_horizontal_gap,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output agac_pkg::score_type                  rsp_cell_score,
   output agac_pkg::score_type                  rsp_vertical_gap,
   output agac_pkg::score_type                  rsp_horizontal_gap,
   output agac_pkg::trace_type                  rsp_trace_code,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [agac_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [agac_pkg::COST_BITS-1:0]       csr_data
);
   import agac_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   item_type   item_in;
   logic       item_valid_ff;
   logic       item_valid_in;
   result_type result;
   result_type result_ff;
   result_type result_in;
   logic       result_valid_ff;
   logic       result_valid_in;
   logic       result_load;
   logic       item_load;

   agac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   agac_calc u_calc (
      .cfg    (cfg),
      .item   (item_ff),
      .result (result)
   );

   // The result register can take a new value when it is empty or being drained this cycle.
   // The input register moves forward whenever the result register can take its content.
   assign result_load = !result_valid_ff || !rsp_stall;
   assign item_load   = !item_valid_ff || result_load;
   assign req_stall   = !item_load;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (item_load) begin
         item_valid_in               = req_valid;
         item_in.ref_char            = req_ref_char;
         item_in.query_char          = req_query_char;
         item_in.above_score         = req_above_score;
         item_in.left_score          = req_left_score;
         item_in.diag_score          = req_diag_score;
         item_in.up_vertical_gap     = req_up_vertical_gap;
         item_in.left_horizontal_gap = req_left_horizontal_gap;
      end
   end

   always_comb begin
      result_in       = result_ff;
      result_valid_in = result_valid_ff;
      if (result_load) begin
         result_valid_in = item_valid_ff;
         result_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         item_valid_ff   <= item_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   // Payload registers carry no reset; the valid flags qualify them.
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_valid          = result_valid_ff;
   assign rsp_cell_score     = result_ff.cell_score;
   assign rsp_vertical_gap   = result_ff.vertical_gap;
   assign rsp_horizontal_gap = result_ff.horizontal_gap;
   assign rsp_trace_code     = result_ff.trace_code;

`ifndef SYNTHESIS
   // Input side only stalls when both stages hold a beat and the output is blocked.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid_ff && result_valid_ff && rsp_stall))
      else $error("input stalled while a stage was free");

   // A padding trace code only ever comes with all scores zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_trace_code == TRACE_PAD) |->
         (rsp_cell_score == '0 && rsp_vertical_gap == '0 && rsp_horizontal_gap == '0))
      else $error("padding result with nonzero score");

   // For a real cell the main score is at least each gap score.
   a_score_dominates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_trace_code != TRACE_PAD) |->
         (rsp_cell_score >= rsp_vertical_gap && rsp_cell_score >= rsp_horizontal_gap))
      else $error("cell score below a gap score");

   // A beat accepted into an empty pipeline reaches the output through the input and result registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !item_valid_ff && !result_valid_ff) |=> ##1 rsp_valid)
      else $error("accepted beat did not reach the result register");

   // Trace code stays within the defined codes.
   a_trace_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_trace_code <= TRACE_UP_EXT))
      else $error("trace code out of range");
`endif

endmodule

// File: test/affine_gap_align_cell_tb.sv
// Self-checking testbench for affine_gap_align_cell: directed and random cell beats under
// random handshake idling, checked against an in-bench Gotoh cell predictor.
// Depends on agac_pkg and affine_gap_align_cell.
`timescale 1ns / 1ps

module affine_gap_align_cell_tb;

   import agac_pkg::*;

   // The cell holds at most two beats (input register and result register), so once the
   // settle wait after the last result has passed the pipeline is certainly empty.
   localparam int          SETTLE_CYCLES = 8;
   localparam int          CYCLE_LIMIT   = 300000;
   localparam int unsigned MAX_IDLE      = 12;
   localparam int unsigned RANDOM_PHASES = 7;
   localparam int unsigned PHASE_BEATS   = 120;
   localparam int unsigned HOLD_BEATS    = 60;
   localparam int unsigned HOLD_CYCLES   = 80;
   localparam int          SCORE_MAX     = (1 << (SCORE_BITS - 1)) - 1;
   localparam int          SCORE_MIN     = -SCORE_MAX - 1;
   localparam int          COST_MAX      = (1 << (COST_BITS - 1)) - 1;
   localparam int          COST_MIN      = -COST_MAX - 1;
   // Indexes past the last defined register must be ignored by the cell.
   localparam int          CSR_FIRST_UNUSED = int'(CSR_MISMATCH_PENALTY) + 1;

   // Every input starts at a known value; reset is held from time zero.
   logic                      clock                   = 1'b0;
   logic                      reset                   = 1'b1;
   logic                      req_valid               = 1'b0;
   logic                      req_stall;
   char_type                  req_ref_char            = '0;
   char_type                  req_query_char          = '0;
   score_type                 req_above_score         = '0;
   score_type                 req_left_score          = '0;
   score_type                 req_diag_score          = '0;
   score_type                 req_up_vertical_gap     = '0;
   score_type                 req_left_horizontal_gap = '0;
   logic                      rsp_valid;
   logic                      rsp_stall               = 1'b0;
   score_type                 rsp_cell_score;
   score_type                 rsp_vertical_gap;
   score_type                 rsp_horizontal_gap;
   trace_type                 rsp_trace_code;
   logic                      csr_valid               = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index               = '0;
   logic [COST_BITS-1:0]      csr_data                = '0;

   // Our own copy of the cost registers, starting from the reset defaults.
   logic     cfg_local    = 1'b0;
   cost_type cfg_open     = -8'sd2;
   cost_type cfg_extend   = -8'sd1;
   cost_type cfg_match    = 8'sd1;
   cost_type cfg_mismatch = -8'sd1;

   item_type    cells_to_send[$];   // beats waiting for the request driver
   result_type  expected_cells[$];  // predicted results, oldest first
   item_type    next_cell;
   int          mismatches     = 0;
   int unsigned req_idle_max   = 0;
   int unsigned rsp_idle_max   = 0;
   int unsigned req_wait       = 0;
   int unsigned rsp_wait       = 0;
   int unsigned hold_request   = 0;
   int unsigned hold_left      = 0;
   logic        req_taken      = 1'b0;
   logic        rsp_taken      = 1'b0;

   affine_gap_align_cell dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_ref_char            (req_ref_char),
      .req_query_char          (req_query_char),
      .req_above_score         (req_above_score),
      .req_left_score          (req_left_score),
      .req_diag_score          (req_diag_score),
      .req_up_vertical_gap     (req_up_vertical_gap),
      .req_left_horizontal_gap (req_left_horizontal_gap),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_cell_score          (rsp_cell_score),
      .rsp_vertical_gap        (rsp_vertical_gap),
      .rsp_horizontal_gap      (rsp_horizontal_gap),
      .rsp_trace_code          (rsp_trace_code),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Cell predictor
   // ---------------------------------------------------------------------------------------

   // A score plus a cost, pinned to the signed score range instead of wrapping.
   function automatic int add_clipped(score_type base, cost_type delta);
      int total;
      total = int'(base) + int'(delta);
      if (total > SCORE_MAX) begin
         total = SCORE_MAX;
      end else if (total < SCORE_MIN) begin
         total = SCORE_MIN;
      end
      return total;
   endfunction

   // Gotoh recurrence for one cell. The diagonal wins any tie; among the gap candidates the
   // order left open, left extend, up open, up extend decides. Only the main score is
   // clamped in local mode, the gap scores pass through as they are.
   function automatic result_type score_cell(item_type beat_in);
      result_type outcome;
      int         left_open, left_ext, up_open, up_ext;
      int         horiz, vert, diag_sum, gap_best, best;
      outcome            = '0;
      outcome.trace_code = TRACE_PAD;
      // A padding query character zeroes the whole result.
      if (beat_in.query_char == '0) begin
         return outcome;
      end
      left_open = add_clipped(beat_in.left_score, cfg_open);
      left_ext  = add_clipped(beat_in.left_horizontal_gap, cfg_extend);
      up_open   = add_clipped(beat_in.above_score, cfg_open);
      up_ext    = add_clipped(beat_in.up_vertical_gap, cfg_extend);
      horiz     = (left_open > left_ext) ? left_open : left_ext;
      vert      = (up_open > up_ext) ? up_open : up_ext;
      diag_sum  = add_clipped(beat_in.diag_score,
                              (beat_in.query_char == beat_in.ref_char) ? cfg_match
                                                                       : cfg_mismatch);
      gap_best  = (horiz > vert) ? horiz : vert;
      best      = (gap_best > diag_sum) ? gap_best : diag_sum;
      if (best == diag_sum) begin
         outcome.trace_code = TRACE_DIAG;
      end else if (best == left_open) begin
         outcome.trace_code = TRACE_LEFT_OPEN;
      end else if (best == left_ext) begin
         outcome.trace_code = TRACE_LEFT_EXT;
      end else if (best == up_open) begin
         outcome.trace_code = TRACE_UP_OPEN;
      end else begin
         outcome.trace_code = TRACE_UP_EXT;
      end
      if (cfg_local && best < 0) begin
         best = 0;
      end
      outcome.cell_score     = score_type'(best);
      outcome.vertical_gap   = score_type'(vert);
      outcome.horizontal_gap = score_type'(horiz);
      return outcome;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request driver: offers queued beats at the falling edge. A beat stays on the port until
   // a rising edge takes it; then the driver idles for the drawn number of cycles before the
   // next one. The valid line is assigned once per edge so back-to-back beats never glitch.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin : request_driver
      logic offer;
      offer = req_valid;
      if (req_valid && req_taken) begin
         offer = 1'b0;
      end
      if (!reset && !offer) begin
         if (req_wait > 0) begin
            req_wait--;
         end else if (cells_to_send.size() != 0) begin
            next_cell = cells_to_send.pop_front();
            req_ref_char            <= next_cell.ref_char;
            req_query_char          <= next_cell.query_char;
            req_above_score         <= next_cell.above_score;
            req_left_score          <= next_cell.left_score;
            req_diag_score          <= next_cell.diag_score;
            req_up_vertical_gap     <= next_cell.up_vertical_gap;
            req_left_horizontal_gap <= next_cell.left_horizontal_gap;
            offer    = 1'b1;
            req_wait = $urandom_range(0, req_idle_max);
         end
      end
      req_valid <= offer;
   end

   // ---------------------------------------------------------------------------------------
   // Result stall: after every result beat the receiver draws a stall length. A long hold
   // requested by the sequence takes precedence and is counted down here, so the cell fills
   // both stages and has to push back on the request side.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin : result_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (rsp_taken) begin
            rsp_wait = $urandom_range(0, rsp_idle_max);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Monitor: at each rising edge a result beat is checked against the oldest prediction,
   // and an accepted request beat gets its prediction queued. The result check comes first
   // so a result leaving in the same cycle always pairs with an older request.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : cell_monitor
      result_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               $error("result beat arrived with no request outstanding");
               mismatches++;
            end else begin
               want = expected_cells.pop_front();
               check_field("cell_score", want.cell_score, rsp_cell_score);
               check_field("vertical_gap", want.vertical_gap, rsp_vertical_gap);
               check_field("horizontal_gap", want.horizontal_gap, rsp_horizontal_gap);
               check_field("trace_code", int'(want.trace_code), int'(rsp_trace_code));
            end
         end
         if (req_valid && !req_stall) begin
            expected_cells.push_back(score_cell(item_type'{
               ref_char:            req_ref_char,
               query_char:          req_query_char,
               above_score:         req_above_score,
               left_score:          req_left_score,
               diag_score:          req_diag_score,
               up_vertical_gap:     req_up_vertical_gap,
               left_horizontal_gap: req_left_horizontal_gap}));
         end
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequence helpers
   // ---------------------------------------------------------------------------------------

   // One register write; our copy of the register follows the write at the accepting edge.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [COST_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LOCAL_MODE:       cfg_local    = data[0];
         CSR_GAP_OPEN:         cfg_open     = cost_type'(data);
         CSR_GAP_EXTEND:       cfg_extend   = cost_type'(data);
         CSR_MATCH_BONUS:      cfg_match    = cost_type'(data);
         CSR_MISMATCH_PENALTY: cfg_mismatch = cost_type'(data);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_config(input logic lmode, input int open_cost, input int ext_cost,
                               input int match_cost, input int mism_cost);
      write_csr(CSR_LOCAL_MODE, {{(COST_BITS-1){1'b0}}, lmode});
      write_csr(CSR_GAP_OPEN, cost_type'(open_cost));
      write_csr(CSR_GAP_EXTEND, cost_type'(ext_cost));
      write_csr(CSR_MATCH_BONUS, cost_type'(match_cost));
      write_csr(CSR_MISMATCH_PENALTY, cost_type'(mism_cost));
   endtask

   // Sets the idle limits of both sides, aligned to a rising edge.
   task automatic start_phase(input int unsigned req_max, input int unsigned rsp_max);
      @(posedge clock);
      req_idle_max = req_max;
      rsp_idle_max = rsp_max;
   endtask

   // The sender stays quiet until every outstanding beat has produced its result, then the
   // settle wait follows before any register is touched.
   task automatic wait_drained();
      do @(posedge clock);
      while (cells_to_send.size() != 0 || req_valid || expected_cells.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic item_type make_cell(char_type rc, char_type qc, int up, int left,
                                          int diag, int vgap, int hgap);
      item_type built;
      built.ref_char            = rc;
      built.query_char          = qc;
      built.above_score         = score_type'(up);
      built.left_score          = score_type'(left);
      built.diag_score          = score_type'(diag);
      built.up_vertical_gap     = score_type'(vgap);
      built.left_horizontal_gap = score_type'(hgap);
      return built;
   endfunction

   // A small alphabet in four of ten draws so matches are frequent, padding in one, any code otherwise.
   function automatic char_type pick_char();
      case ($urandom_range(0, 9))
         0:             return '0;
         1, 2, 3, 4:    return char_type'($urandom_range(1, 4));
         default:       return char_type'($urandom_range(0, 255));
      endcase
   endfunction

   // Small scores make ties common; the edge bands exercise saturation in both directions.
   function automatic score_type pick_score();
      case ($urandom_range(0, 4))
         0, 1:    return score_type'(int'($urandom_range(0, 400)) - 200);
         2:       return score_type'(SCORE_MAX - int'($urandom_range(0, 300)));
         3:       return score_type'(SCORE_MIN + int'($urandom_range(0, 300)));
         default: return score_type'($urandom);
      endcase
   endfunction

   function automatic int pick_cost();
      if ($urandom_range(0, 3) == 0) begin
         return int'(cost_type'($urandom_range(0, 255)));
      end
      return int'($urandom_range(0, 16)) - 8;
   endfunction

   function automatic int unsigned pick_idle();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 3;
         default: return MAX_IDLE;
      endcase
   endfunction

   function automatic item_type random_cell();
      return item_type'{
         ref_char:            pick_char(),
         query_char:          pick_char(),
         above_score:         pick_score(),
         left_score:          pick_score(),
         diag_score:          pick_score(),
         up_vertical_gap:     pick_score(),
         left_horizontal_gap: pick_score()};
   endfunction

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------
   initial begin : sequence_main
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Writes to undefined indexes must leave the reset costs alone, which the directed
      // beats below then depend on.
      for (int idx = CSR_FIRST_UNUSED; idx < (1 << CSR_INDEX_BITS); idx++) begin
         write_csr(CSR_INDEX_BITS'(idx), COST_BITS'($urandom_range(0, 255)));
      end

      // Reset costs in global mode: padding, match and mismatch, each trace direction,
      // ties between diagonal and gap and between the gap candidates, and saturation.
      start_phase(3, 3);
      cells_to_send.push_back(make_cell(8'h41, 8'h00, 100, -300, 5000, 77, -9));
      cells_to_send.push_back(make_cell(8'hFF, 8'hFF, -1000, -1000, 100, -1000, -1000));
      cells_to_send.push_back(make_cell(8'h01, 8'h80, -1000, -1000, 100, -1000, -1000));
      cells_to_send.push_back(make_cell(8'h03, 8'h03, -1000, 12, 9, -1000, -1000));
      cells_to_send.push_back(make_cell(8'h01, 8'h02, 0, 0, 0, 0, 50));
      cells_to_send.push_back(make_cell(8'h01, 8'h02, 60, 0, 0, 0, 0));
      cells_to_send.push_back(make_cell(8'h01, 8'h02, 0, 0, 0, 70, 0));
      cells_to_send.push_back(make_cell(8'h01, 8'h02, 0, 21, 0, 0, 20));
      cells_to_send.push_back(make_cell(8'h01, 8'h02, 32, 0, 0, 31, 0));
      cells_to_send.push_back(make_cell(8'h07, 8'h09, SCORE_MIN, SCORE_MIN, SCORE_MIN,
                                        SCORE_MIN, SCORE_MIN));
      cells_to_send.push_back(make_cell(8'hAA, 8'hAA, SCORE_MAX, SCORE_MAX, SCORE_MAX,
                                        SCORE_MAX, SCORE_MAX));
      cells_to_send.push_back(make_cell(8'h01, 8'h02, -500, -500, -500, -500, -500));
      wait_drained();

      // Local mode clamps only the main score; padding still zeroes everything.
      write_csr(CSR_LOCAL_MODE, 8'h01);
      start_phase(0, 0);
      cells_to_send.push_back(make_cell(8'h01, 8'h02, -500, -500, -500, -500, -500));
      cells_to_send.push_back(make_cell(8'h55, 8'h00, -7, 9, -11, 13, -15));
      wait_drained();

      // Largest costs: sums pinned at the top, or pulled up from the bottom and clamped.
      apply_config(1'b1, COST_MAX, COST_MAX, COST_MAX, COST_MAX);
      start_phase(MAX_IDLE, 0);
      cells_to_send.push_back(make_cell(8'h10, 8'h10, SCORE_MAX, SCORE_MAX, SCORE_MAX,
                                        SCORE_MAX, SCORE_MAX));
      cells_to_send.push_back(make_cell(8'h10, 8'h20, SCORE_MIN, SCORE_MIN, SCORE_MIN,
                                        SCORE_MIN, SCORE_MIN));
      wait_drained();

      // Smallest costs in global mode: sums pinned at the bottom, a zero reference code
      // that is not padding.
      apply_config(1'b0, COST_MIN, COST_MIN, COST_MIN, COST_MIN);
      start_phase(0, MAX_IDLE);
      cells_to_send.push_back(make_cell(8'h31, 8'h32, SCORE_MIN, SCORE_MIN, SCORE_MIN,
                                        SCORE_MIN, SCORE_MIN));
      cells_to_send.push_back(make_cell(8'h31, 8'h32, SCORE_MAX, SCORE_MAX, SCORE_MAX,
                                        SCORE_MAX, SCORE_MAX));
      cells_to_send.push_back(make_cell(8'h00, 8'h01, 0, 0, 0, 0, 0));
      wait_drained();

      write_csr(CSR_LOCAL_MODE, 8'h01);
      start_phase(3, 3);
      cells_to_send.push_back(make_cell(8'h02, 8'h02, 0, 0, 0, 0, 0));
      cells_to_send.push_back(make_cell(8'h02, 8'h03, 100, -100, 5, 200, -200));
      wait_drained();

      // Random phases, each under its own costs and idling; two use the cost extremes.
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 2) begin
            apply_config(1'b0, COST_MIN, COST_MIN, COST_MIN, COST_MIN);
         end else if (phase == 5) begin
            apply_config(1'b1, COST_MAX, COST_MAX, COST_MAX, COST_MAX);
         end else begin
            apply_config(1'($urandom_range(0, 1)), pick_cost(), pick_cost(), pick_cost(),
                         pick_cost());
         end
         start_phase(pick_idle(), pick_idle());
         for (int unsigned n = 0; n < PHASE_BEATS; n++) begin
            cells_to_send.push_back(random_cell());
         end
         wait_drained();

         // Back pressure: the sender streams while the receiver holds off long enough for
         // both pipeline stages to fill and the request side to stall.
         if (phase == 3) begin
            start_phase(0, 0);
            for (int unsigned n = 0; n < HOLD_BEATS; n++) begin
               cells_to_send.push_back(random_cell());
            end
            hold_request = HOLD_CYCLES;
            wait_drained();
         end
      end

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Generous bound on the whole run: even every beat waiting out the longest idle on both
   // sides stays far below it.
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
src/agac_pkg.sv
src/agac_csr.sv
src/agac_calc.sv
src/affine_gap_align_cell.sv
test/affine_gap_align_cell_tb.sv
